FILE: src/srtf_pkg.sv
// Shared constants and types for the SRTF scheduler.
package srtf_pkg;

	localparam int SLOTS  = 8;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ID_W   = 8;
	localparam int REM_W  = 16;
	localparam int TIME_W = 32;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_ARRIVE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARR,
		ST_SCAN,
		ST_DEC,
		ST_TAT,
		ST_WT,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		SUB_CMP,
		SUB_DEC,
		SUB_TAT,
		SUB_WT
	} sub_sel_t;

endpackage

FILE: src/srtf_scheduler.sv
// Top level of the shortest-remaining-time-first scheduler.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------------
//  in      | in_valid / in_stall   | cmd, job_id, burst_len
//  out     | out_valid / out_stall | accepted, busy_res, run_id, finished,
//          |                       | turnaround, wait_time
//
// One transaction in at a time; in_stall is high while an item is in work.
// Arrival: accept, store (ST_ARR) and finish (ST_FIN) in that order; finish loads the output register.
// Tick: scan, decrement, then turnaround and waiting time when the served job completes, then finish; the scan
// visits one slot per cycle through the shared subtractor, which then also
// forms the decrement, the turnaround and the waiting time in turn.
// A result waits in the output register; the next item is taken meanwhile, and
// only the finish step waits while out_stall holds a full output register.
// arst_n clears all slot valid bits, the clock and the control state at once.
module srtf_scheduler (
	input  logic                       clk,
	input  logic                       arst_n,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  logic [srtf_pkg::ID_W-1:0]   job_id,
	input  logic [srtf_pkg::REM_W-1:0]  burst_len,
	// output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       accepted,
	output logic                       busy_res,
	output logic [srtf_pkg::ID_W-1:0]   run_id,
	output logic                       finished,
	output logic [srtf_pkg::TIME_W-1:0] turnaround,
	output logic [srtf_pkg::TIME_W-1:0] wait_time
);

	localparam int IDX_W  = srtf_pkg::IDX_W;
	localparam int ID_W   = srtf_pkg::ID_W;
	localparam int REM_W  = srtf_pkg::REM_W;
	localparam int TIME_W = srtf_pkg::TIME_W;
	localparam int SLOTS  = srtf_pkg::SLOTS;

	srtf_pkg::state_t state_q, state_d;

	// slot table: valid bits reset, payload written on arrival, remaining time also on each decrement
	logic [SLOTS-1:0]  valid_q;
	logic [ID_W-1:0]   job_q     [SLOTS];
	logic [REM_W-1:0]  rem_q     [SLOTS];
	logic [REM_W-1:0]  burst_q   [SLOTS];
	logic [TIME_W-1:0] arrival_q [SLOTS];
	logic [TIME_W-1:0] now_q;

	// captured input transaction
	logic              cmd_q;
	logic [ID_W-1:0]   in_id_q;
	logic [REM_W-1:0]  in_burst_q;

	// scan state
	logic [IDX_W-1:0]  scan_idx_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [REM_W-1:0]  best_rem_q;
	logic              found_q;

	// result being built
	logic              res_acc_q;
	logic              res_busy_q;
	logic [ID_W-1:0]   res_id_q;
	logic              res_fin_q;
	logic [TIME_W-1:0] res_tat_q;
	logic [TIME_W-1:0] res_wt_q;

	// output register
	logic              out_valid_q;
	logic              acc_out_q;
	logic              busy_out_q;
	logic [ID_W-1:0]   id_out_q;
	logic              fin_out_q;
	logic [TIME_W-1:0] tat_out_q;
	logic [TIME_W-1:0] wt_out_q;

	// decoded controls
	logic                 in_take;
	logic                 out_free;
	logic                 scan_last;
	logic [IDX_W-1:0]     rd_idx;
	logic [REM_W-1:0]     rem_rd;
	srtf_pkg::sub_sel_t   sub_sel;
	logic [TIME_W-1:0]    sub_a;
	logic [TIME_W-1:0]    sub_b;
	logic [TIME_W:0]      sub_diff;
	logic                 rem_less;
	logic                 dec_zero;
	logic                 free_any;
	logic [IDX_W-1:0]     free_idx;
	logic                 arr_store;

	assign in_stall  = (state_q != srtf_pkg::ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign scan_last = (scan_idx_q == IDX_W'(SLOTS - 1));

	// one read port into the remaining-time table: scan index while scanning, picked slot after
	assign rd_idx = (state_q == srtf_pkg::ST_SCAN) ? scan_idx_q : best_idx_q;
	assign rem_rd = rem_q[rd_idx];

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(k);
			end
		end
	end

	assign arr_store = (state_q == srtf_pkg::ST_ARR) && free_any && (in_burst_q != '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			srtf_pkg::ST_IDLE: begin
				if (in_take) begin
					state_d = (cmd == srtf_pkg::CMD_ARRIVE) ? srtf_pkg::ST_ARR
						: srtf_pkg::ST_SCAN;
				end
			end
			srtf_pkg::ST_ARR:  state_d = srtf_pkg::ST_FIN;
			srtf_pkg::ST_SCAN: begin
				if (scan_last) state_d = srtf_pkg::ST_DEC;
			end
			srtf_pkg::ST_DEC: begin
				state_d = (found_q && dec_zero) ? srtf_pkg::ST_TAT : srtf_pkg::ST_FIN;
			end
			srtf_pkg::ST_TAT:  state_d = srtf_pkg::ST_WT;
			srtf_pkg::ST_WT:   state_d = srtf_pkg::ST_FIN;
			srtf_pkg::ST_FIN: begin
				if (out_free) state_d = srtf_pkg::ST_IDLE;
			end
			default:           state_d = srtf_pkg::ST_IDLE;
		endcase
	end

	// shared subtractor operand select
	always_comb begin
		case (state_q)
			srtf_pkg::ST_DEC: sub_sel = srtf_pkg::SUB_DEC;
			srtf_pkg::ST_TAT: sub_sel = srtf_pkg::SUB_TAT;
			srtf_pkg::ST_WT:  sub_sel = srtf_pkg::SUB_WT;
			default:          sub_sel = srtf_pkg::SUB_CMP;
		endcase
	end

	always_comb begin
		case (sub_sel)
			srtf_pkg::SUB_CMP: begin
				sub_a = {{(TIME_W-REM_W){1'b0}}, rem_rd};
				sub_b = {{(TIME_W-REM_W){1'b0}}, best_rem_q};
			end
			srtf_pkg::SUB_DEC: begin
				sub_a = {{(TIME_W-REM_W){1'b0}}, rem_rd};
				sub_b = TIME_W'(1);
			end
			srtf_pkg::SUB_TAT: begin
				sub_a = now_q;
				sub_b = arrival_q[best_idx_q];
			end
			srtf_pkg::SUB_WT: begin
				sub_a = res_tat_q;
				sub_b = {{(TIME_W-REM_W){1'b0}}, burst_q[best_idx_q]};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign rem_less = sub_diff[TIME_W];           // borrow: rem_rd < best_rem_q
	assign dec_zero = (sub_diff[REM_W-1:0] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srtf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state: valid bits, clock, scan bookkeeping, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			now_q       <= '0;
			scan_idx_q  <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end
			if (state_q == srtf_pkg::ST_SCAN) begin
				if (!scan_last) scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (valid_q[scan_idx_q] && (!found_q || rem_less)) found_q <= 1'b1;
			end
			if (arr_store) valid_q[free_idx] <= 1'b1;
			if (state_q == srtf_pkg::ST_DEC) now_q <= now_q + TIME_W'(1);
			if (state_q == srtf_pkg::ST_TAT) valid_q[best_idx_q] <= 1'b0;
			if (state_q == srtf_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q      <= cmd;
			in_id_q    <= job_id;
			in_burst_q <= burst_len;
			res_acc_q  <= 1'b0;
			res_busy_q <= 1'b0;
			res_id_q   <= '0;
			res_fin_q  <= 1'b0;
			res_tat_q  <= '0;
			res_wt_q   <= '0;
		end
		if (state_q == srtf_pkg::ST_SCAN) begin
			if (valid_q[scan_idx_q] && (!found_q || rem_less)) begin
				best_idx_q <= scan_idx_q;
				best_rem_q <= rem_rd;
			end
		end
		if (arr_store) begin
			job_q[free_idx]     <= in_id_q;
			rem_q[free_idx]     <= in_burst_q;
			burst_q[free_idx]   <= in_burst_q;
			arrival_q[free_idx] <= now_q;
			res_acc_q           <= 1'b1;
		end
		if (state_q == srtf_pkg::ST_DEC && found_q) begin
			rem_q[best_idx_q] <= sub_diff[REM_W-1:0];
			res_busy_q        <= 1'b1;
			res_id_q          <= job_q[best_idx_q];
			res_fin_q         <= dec_zero;
		end
		if (state_q == srtf_pkg::ST_TAT) res_tat_q <= sub_diff[TIME_W-1:0];
		if (state_q == srtf_pkg::ST_WT)  res_wt_q  <= sub_diff[TIME_W-1:0];
		if (state_q == srtf_pkg::ST_FIN && out_free) begin
			acc_out_q  <= res_acc_q && (cmd_q == srtf_pkg::CMD_ARRIVE);
			busy_out_q <= res_busy_q;
			id_out_q   <= res_id_q;
			fin_out_q  <= res_fin_q;
			tat_out_q  <= res_tat_q;
			wt_out_q   <= res_wt_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = acc_out_q;
	assign busy_res   = busy_out_q;
	assign run_id     = id_out_q;
	assign finished   = fin_out_q;
	assign turnaround = tat_out_q;
	assign wait_time  = wt_out_q;

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the SRTF scheduler: directed cases, then random traffic.
module tb_top;

	localparam int SLOTS  = srtf_pkg::SLOTS;
	localparam int ID_W   = srtf_pkg::ID_W;
	localparam int REM_W  = srtf_pkg::REM_W;
	localparam int TIME_W = srtf_pkg::TIME_W;

	// One result transaction as the block reports it.
	typedef struct {
		logic              accepted;
		logic              busy;
		logic [ID_W-1:0]   run_id;
		logic              finished;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] wait_time;
	} sched_result_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic              cmd       = srtf_pkg::CMD_TICK;
	logic [ID_W-1:0]   job_id    = '0;
	logic [REM_W-1:0]  burst_len = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              accepted;
	logic              busy_res;
	logic [ID_W-1:0]   run_id;
	logic              finished;
	logic [TIME_W-1:0] turnaround;
	logic [TIME_W-1:0] wait_time;

	// Predicted job table, mirrors what the block should hold.
	bit                slot_live  [SLOTS];
	logic [ID_W-1:0]   slot_owner [SLOTS];
	logic [REM_W-1:0]  slot_left  [SLOTS];
	logic [REM_W-1:0]  slot_len   [SLOTS];
	logic [TIME_W-1:0] slot_stamp [SLOTS];
	logic [TIME_W-1:0] sched_now = '0;

	// Expected results, oldest first.
	sched_result_t     pending_results[$];
	int                err_count = 0;

	// Idle control: calm flags turn gaps off, hold request forces a long output stall.
	bit                tx_calm = 1'b0;
	bit                rx_calm = 1'b0;
	int                rx_hold_req = 0;
	int                rx_left = 0;

	srtf_scheduler dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.job_id     (job_id),
		.burst_len  (burst_len),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.accepted   (accepted),
		.busy_res   (busy_res),
		.run_id     (run_id),
		.finished   (finished),
		.turnaround (turnaround),
		.wait_time  (wait_time)
	);

	always #5 clk = ~clk;

	// Hard stop; several times the slowest legal run.
	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

	// SRTF prediction for one accepted transaction. Updates the predicted table.
	function automatic sched_result_t srtf_predict(input logic c, input logic [ID_W-1:0] id,
			input logic [REM_W-1:0] bl);
		sched_result_t r;
		int            pick;
		int            k;
		r = '{default: '0};
		pick = -1;
		if (c == srtf_pkg::CMD_ARRIVE) begin
			// zero burst is rejected; otherwise lowest free slot, stamped with current time
			if (bl != '0) begin
				for (k = 0; k < SLOTS; k++) begin
					if (!slot_live[k] && pick < 0) begin
						pick = k;
					end
				end
				if (pick >= 0) begin
					slot_live[pick]  = 1'b1;
					slot_owner[pick] = id;
					slot_left[pick]  = bl;
					slot_len[pick]   = bl;
					slot_stamp[pick] = sched_now;
					r.accepted       = 1'b1;
				end
			end
		end else begin
			// strict less-than keeps ties on the lowest slot
			for (k = 0; k < SLOTS; k++) begin
				if (slot_live[k] && (pick < 0 || slot_left[k] < slot_left[pick])) begin
					pick = k;
				end
			end
			sched_now = sched_now + TIME_W'(1);
			if (pick >= 0) begin
				r.busy           = 1'b1;
				r.run_id         = slot_owner[pick];
				slot_left[pick]  = slot_left[pick] - REM_W'(1);
				if (slot_left[pick] == '0) begin
					r.finished      = 1'b1;
					r.turnaround    = sched_now - slot_stamp[pick];
					r.wait_time     = r.turnaround - TIME_W'(slot_len[pick]);
					slot_live[pick] = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		if ($urandom_range(9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [REM_W-1:0] rand_burst();
		int p;
		p = $urandom_range(99);
		if (p < 5) begin
			return '0;
		end
		if (p < 80) begin
			return REM_W'($urandom_range(1, 3));
		end
		return REM_W'($urandom_range(4, 12));
	endfunction

	// Offer one transaction and hold it until taken. Valid stays high when the
	// next transaction follows at once, so it is never dropped and raised in one step.
	task automatic send_item(input logic c, input logic [ID_W-1:0] id,
			input logic [REM_W-1:0] bl);
		int gap;
		in_valid  <= 1'b1;
		cmd       <= c;
		job_id    <= id;
		burst_len <= bl;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(srtf_predict(c, id, bl));
		gap = (tx_calm || $urandom_range(1) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Ticks carry random don't-care payload.
	task automatic tick_once();
		send_item(srtf_pkg::CMD_TICK, ID_W'($urandom_range(255)),
			REM_W'($urandom_range(16'hffff)));
	endtask

	task automatic send_arrival(input logic [ID_W-1:0] id, input logic [REM_W-1:0] bl);
		send_item(srtf_pkg::CMD_ARRIVE, id, bl);
	endtask

	// Ticks on an empty table still advance the clock.
	task automatic test_idle_ticks();
		repeat (2) tick_once();
	endtask

	task automatic test_zero_burst();
		send_arrival(8'h5a, '0);
	endtask

	// A shorter job arriving mid-run takes over, then the first one resumes.
	task automatic test_preemption();
		send_arrival(8'h11, 16'd3);
		tick_once();
		send_arrival(8'h22, 16'd1);
		tick_once();
		tick_once();
		tick_once();
	endtask

	// Fill every slot (longest burst first, it never finishes), one extra is
	// rejected, then the one-tick jobs drain in slot order since they all tie.
	task automatic test_table_full();
		int k;
		send_arrival(8'h00, 16'hffff);
		for (k = 1; k < SLOTS; k++) begin
			send_arrival((k == SLOTS - 1) ? 8'hff : ID_W'(k * 17), 16'd1);
		end
		send_arrival(8'h77, 16'd1);
		repeat (SLOTS - 1) tick_once();
	endtask

	// Receiver holds off while the sender keeps going, so the block backs up.
	task automatic test_backpressure();
		int k;
		tx_calm     = 1'b1;
		rx_hold_req = 200;
		for (k = 0; k < 12; k++) begin
			if (k % 2 == 0) begin
				send_arrival(ID_W'($urandom_range(255)), REM_W'($urandom_range(1, 3)));
			end else begin
				tick_once();
			end
		end
		tx_calm = 1'b0;
	endtask

	// Chunks of 20 with varying arrival mix; some chunks run with no idling.
	task automatic test_random_mix(input int n_items);
		int sent;
		int arr_pct;
		int j;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(2))
				0: arr_pct = 20;
				1: arr_pct = 35;
				default: arr_pct = 60;
			endcase
			tx_calm = ($urandom_range(3) == 0);
			rx_calm = ($urandom_range(3) == 0);
			for (j = 0; j < 20; j++) begin
				if ($urandom_range(99) < arr_pct) begin
					send_arrival(ID_W'($urandom_range(255)), rand_burst());
				end else begin
					tick_once();
				end
			end
			sent += 20;
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// Output stall: forced hold first, else random short/long stalls unless calm.
	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_left     = rx_hold_req;
			rx_hold_req = 0;
		end else if (rx_left == 0 && !rx_calm && $urandom_range(99) < 30) begin
			rx_left = idle_len();
		end
		if (rx_left > 0) begin
			out_stall <= 1'b1;
			rx_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result check against the oldest expectation.
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= 10) begin
					$display("unexpected result: acc=%0d busy=%0d id=%0d fin=%0d tat=%0d wt=%0d",
						accepted, busy_res, run_id, finished, turnaround, wait_time);
				end
			end else begin
				want = pending_results.pop_front();
				if (accepted !== want.accepted || busy_res !== want.busy ||
						run_id !== want.run_id || finished !== want.finished ||
						turnaround !== want.turnaround || wait_time !== want.wait_time) begin
					err_count++;
					if (err_count <= 10) begin
						$display("mismatch: exp acc=%0d busy=%0d id=%0d fin=%0d tat=%0d wt=%0d",
							want.accepted, want.busy, want.run_id, want.finished,
							want.turnaround, want.wait_time);
						$display("          got acc=%0d busy=%0d id=%0d fin=%0d tat=%0d wt=%0d",
							accepted, busy_res, run_id, finished, turnaround, wait_time);
					end
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_zero_burst();
		test_preemption();
		test_table_full();
		test_backpressure();
		test_random_mix(400);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// stray results from the block would show up during this wait
		repeat (4 * SLOTS) @(posedge clk);
		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/srtf_pkg.sv
src/srtf_scheduler.sv
bench/tb_top.sv
